@@ rtl/grbf_pkg.sv @@
package grbf_pkg;

    localparam int DIV_BITS     = 21;
    localparam int HORNER_TERMS = 12;
    localparam int SQUARE_STEPS = 4;
    localparam int RECIP_SHIFT  = 34;
    localparam int LIM_SHIFT    = 19;

    localparam int ST_CLASS   = 4;
    localparam int ST_RANGE   = 5;
    localparam int NUM_STAGES = ST_RANGE + 1 + DIV_BITS + 3 * HORNER_TERMS + SQUARE_STEPS + 1;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [15:0] OUT_ONE = 16'd32768;

    localparam logic [2:0] REG_CENTER_X      = 3'd0;
    localparam logic [2:0] REG_CENTER_Y      = 3'd1;
    localparam logic [2:0] REG_COV_XX        = 3'd2;
    localparam logic [2:0] REG_COV_XY        = 3'd3;
    localparam logic [2:0] REG_COV_YX        = 3'd4;
    localparam logic [2:0] REG_COV_YY        = 3'd5;
    localparam logic [2:0] REG_CONSTANT_MODE = 3'd6;

    typedef struct packed {
        logic last;
        logic sing;
        logic neg;
        logic big;
    } t_flags;

endpackage

@@ rtl/gaussian_rbf_kernel_2d.sv @@
// gaussian rbf kernel, 2-d mahalanobis form, streaming
// config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   o_cfg_ready is always high, writes must only be issued while no point is in flight
// input channel: i_valid/o_ready carrying i_feature_x, i_feature_y, i_last_in
// output channel: o_valid/i_ready carrying o_kernel_value (q1.15), o_invalid_cov,
//   o_last_out
// throughput: one point per cycle while the output is not stalled; 68 register
//   stages lie between acceptance and o_valid (front end products, 21 stages
//   of the restoring divider, 12 horner terms of 3 stages each, 4 squarings,
//   output register)
// reset: synchronous active low, clears all valid bits and loads the default
//   registers (center 0, identity covariance, constant mode off)
// stall: when the output transaction waits, the whole pipeline holds and
//   o_ready drops; nothing is lost or repeated
module gaussian_rbf_kernel_2d
    import grbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [15:0] i_feature_x,
    input  logic signed [15:0] i_feature_y,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_kernel_value,
    output logic        o_invalid_cov,
    output logic        o_last_out
);

    logic signed [15:0] r_center_x, r_center_y;
    logic signed [15:0] r_cov_xx, r_cov_xy, r_cov_yx, r_cov_yy;
    logic               r_constant_mode;

    logic signed [31:0] r_ad, r_bc;
    logic signed [32:0] r_det;
    logic        [31:0] r_absd;
    logic        [51:0] r_lim;

    logic [NUM_STAGES-1:0] r_vld;
    t_flags r_flg [NUM_STAGES];
    t_flags n_flg [NUM_STAGES];
    logic   en;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_vld[NUM_STAGES-1] || i_ready;
    assign o_ready     = en;
    assign o_valid     = r_vld[NUM_STAGES-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= '0;
            r_center_y      <= '0;
            r_cov_xx        <= 16'sd256;
            r_cov_xy        <= '0;
            r_cov_yx        <= '0;
            r_cov_yy        <= 16'sd256;
            r_constant_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_X:      r_center_x      <= i_cfg_data;
                REG_CENTER_Y:      r_center_y      <= i_cfg_data;
                REG_COV_XX:        r_cov_xx        <= i_cfg_data;
                REG_COV_XY:        r_cov_xy        <= i_cfg_data;
                REG_COV_YX:        r_cov_yx        <= i_cfg_data;
                REG_COV_YY:        r_cov_yy        <= i_cfg_data;
                REG_CONSTANT_MODE: r_constant_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // determinant and range limit, derived from the static config
    always_ff @(posedge i_clk) begin
        r_ad   <= r_cov_xx * r_cov_yy;
        r_bc   <= r_cov_xy * r_cov_yx;
        r_det  <= 33'(r_ad) - 33'(r_bc);
        r_absd <= 32'(r_det[32] ? -r_det : r_det);
        r_lim  <= (52'(r_absd) + (52'(r_absd) << 1)) << LIM_SHIFT;
    end

    // valid bits and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
        end
    end

    logic signed [50:0] r_num;
    logic        [50:0] num_abs;
    logic        [57:0] r_dvd;

    assign num_abs = r_num[50] ? 51'(-r_num) : 51'(r_num);

    always_comb begin
        n_flg[0] = '{last: i_last_in, sing: 1'b0, neg: 1'b0, big: 1'b0};
        for (int s = 1; s < NUM_STAGES; s++) begin
            n_flg[s] = r_flg[s-1];
        end
        n_flg[ST_CLASS].sing = (r_det == '0);
        n_flg[ST_CLASS].neg  = (r_num != '0) && (r_num[50] != r_det[32]);
        n_flg[ST_RANGE].big  = (r_dvd >= 58'(r_lim));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_flg[s] <= n_flg[s];
            end
        end
    end

    // front end: differences, products, quadratic numerator
    logic signed [16:0] r_dx, r_dy;
    logic signed [33:0] r_xx, r_yy, r_xy;
    logic signed [50:0] r_t1, r_t2, r_t3;
    logic signed [16:0] bc_sum;

    assign bc_sum = 17'(r_cov_xy) + 17'(r_cov_yx);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx  <= 17'(i_feature_x) - 17'(r_center_x);
            r_dy  <= 17'(i_feature_y) - 17'(r_center_y);
            r_xx  <= 34'(r_dx) * 34'(r_dx);
            r_yy  <= 34'(r_dy) * 34'(r_dy);
            r_xy  <= 34'(r_dx) * 34'(r_dy);
            r_t1  <= 51'(r_xx) * 51'(r_cov_yy);
            r_t2  <= 51'(r_xy) * 51'(bc_sum);
            r_t3  <= 51'(r_yy) * 51'(r_cov_xx);
            r_num <= r_t1 - r_t2 + r_t3;
            r_dvd <= {num_abs[49:0], 8'b0};
        end
    end

    // restoring divider, one quotient bit per stage
    logic [57:0]         w_rem [DIV_BITS+1];
    logic [DIV_BITS-1:0] w_quo [DIV_BITS+1];

    logic [57:0] r_rem0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem0 <= r_dvd;
        end
    end
    assign w_rem[0] = r_rem0;
    assign w_quo[0] = '0;

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int B = DIV_BITS - 1 - j;
        logic [57:0]         sh;
        logic                ge;
        logic [57:0]         r_rem;
        logic [DIV_BITS-1:0] r_quo;

        assign sh = 58'(r_absd) << B;
        assign ge = (w_rem[j] >= sh);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem <= ge ? (w_rem[j] - sh) : w_rem[j];
                r_quo <= w_quo[j] | (DIV_BITS'(ge) << B);
            end
        end
        assign w_rem[j+1] = r_rem;
        assign w_quo[j+1] = r_quo;
    end

    // horner series for exp(-q/32)
    logic [29:0] hr_r   [HORNER_TERMS+1];
    logic [30:0] hr_acc [HORNER_TERMS+1];

    assign hr_r[0]   = {w_quo[DIV_BITS], 9'b0};
    assign hr_acc[0] = Q30_ONE;

    for (genvar h = 0; h < HORNER_TERMS; h++) begin : g_horner
        localparam int          K = HORNER_TERMS - h;
        localparam logic [34:0] M = 35'((64'd1 << RECIP_SHIFT) / K);
        logic [60:0] prod;
        logic [64:0] qm;
        logic [33:0] rem;
        logic        ge;
        logic [29:0] r_t, r_t2, r_q0;
        logic [29:0] r_r1, r_r2, r_r3;
        logic [30:0] r_acc;

        assign prod = 61'(hr_r[h]) * 61'(hr_acc[h]);
        assign qm   = 65'(r_t) * 65'(M);
        assign rem  = 34'(r_t2) - 34'(r_q0) * 34'(K);
        assign ge   = (rem >= 34'(K));

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_t   <= prod[59:30];
                r_r1  <= hr_r[h];
                r_q0  <= qm[63:34];
                r_t2  <= r_t;
                r_r2  <= r_r1;
                r_acc <= Q30_ONE - 31'(r_q0 + 30'(ge));
                r_r3  <= r_r2;
            end
        end
        assign hr_acc[h+1] = r_acc;
        assign hr_r[h+1]   = r_r3;
    end

    // four squarings give exp(-q/2)
    logic [30:0] sq [SQUARE_STEPS+1];
    assign sq[0] = hr_acc[HORNER_TERMS];

    for (genvar k = 0; k < SQUARE_STEPS; k++) begin : g_square
        logic [61:0] p;
        logic [30:0] r_sq;
        assign p = 62'(sq[k]) * 62'(sq[k]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq <= p[60:30];
            end
        end
        assign sq[k+1] = r_sq;
    end

    // output register
    logic [30:0] rnd;
    logic [15:0] out_val;
    logic        out_bad;
    t_flags      fin;
    logic [15:0] r_out_val;
    logic        r_out_bad;

    assign rnd = sq[SQUARE_STEPS] + 31'(1 << 14);
    assign fin = r_flg[NUM_STAGES-2];

    always_comb begin
        out_val = rnd[30:15];
        out_bad = 1'b0;
        if (r_constant_mode) begin
            out_val = OUT_ONE;
        end else if (fin.sing) begin
            out_val = '0;
            out_bad = 1'b1;
        end else if (fin.neg) begin
            out_val = OUT_ONE;
            out_bad = 1'b1;
        end else if (fin.big) begin
            out_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= out_val;
            r_out_bad <= out_bad;
        end
    end

    assign o_kernel_value = r_out_val;
    assign o_invalid_cov  = r_out_bad;
    assign o_last_out     = r_flg[NUM_STAGES-1].last;

endmodule

@@ rtl/grbf_checker.sv @@
module grbf_checker
    import grbf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_kernel_value,
    input logic        o_invalid_cov,
    input logic        o_last_out
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kernel_value)
            && $stable(o_invalid_cov) && $stable(o_last_out))
        else $error("output transaction changed while stalled");

    // input is refused only behind a stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused without output stall");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kernel_value <= OUT_ONE)
        else $error("kernel value above one");

    a_bad_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid_cov |-> o_kernel_value == '0 || o_kernel_value == OUT_ONE)
        else $error("invalid covariance result not saturated");

endmodule

bind gaussian_rbf_kernel_2d grbf_checker u_grbf_checker (.*);

@@ tb/sv/tb_gaussian_rbf_kernel_2d.sv @@
module tb_gaussian_rbf_kernel_2d;
    import grbf_pkg::*;

    localparam int LATENCY = NUM_STAGES + 4;
    localparam int LIMIT   = 600000;

    class grbf_scoreboard;
        typedef struct {
            logic [15:0] value;
            logic        bad;
            logic        last;
        } t_kernel_result;

        logic signed [15:0] cx, cy, cxx, cxy, cyx, cyy;
        logic               cmode;
        t_kernel_result     pending[$];
        int                 errors, points, results, n_bad, n_zero, n_mid;

        function new();
            cx = '0; cy = '0; cxx = 16'sd256; cxy = '0; cyx = '0; cyy = 16'sd256;
            cmode = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_CENTER_X:      cx = data;
                REG_CENTER_Y:      cy = data;
                REG_COV_XX:        cxx = data;
                REG_COV_XY:        cxy = data;
                REG_COV_YX:        cyx = data;
                REG_COV_YY:        cyy = data;
                REG_CONSTANT_MODE: cmode = data[0];
                default: ;
            endcase
        endfunction

        // exp(-q/2) in q1.15 from q in q.16
        function longint unsigned half_exp(longint unsigned q16);
            longint unsigned one, r, acc, res;
            one = 64'd1 << 30;
            r = q16 << 9;
            acc = one;
            for (int k = 12; k >= 1; k--) begin
                acc = one - ((r * acc) >> 30) / k;
            end
            for (int i = 0; i < 4; i++) begin
                acc = (acc * acc) >> 30;
            end
            res = (acc * 32768 + (one >> 1)) >> 30;
            if (res > 32768) begin
                res = 32768;
            end
            return res;
        endfunction

        function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
            t_kernel_result  e;
            longint          dx, dy, a, b, c, d, det, num;
            longint unsigned q16, anum, adet;
            e.last = last;
            e.bad = 1'b0;
            points++;
            if (cmode) begin
                e.value = OUT_ONE;
            end else begin
                dx = longint'(x) - longint'(cx);
                dy = longint'(y) - longint'(cy);
                a = cxx; b = cxy; c = cyx; d = cyy;
                det = a * d - b * c;
                num = dx * dx * d - dx * dy * (b + c) + dy * dy * a;
                if (det == 0) begin
                    e.value = '0;
                    e.bad = 1'b1;
                end else if (num != 0 && ((num < 0) != (det < 0))) begin
                    e.value = OUT_ONE;
                    e.bad = 1'b1;
                end else begin
                    anum = (num < 0) ? -num : num;
                    adet = (det < 0) ? -det : det;
                    q16 = (anum * 256) / adet;
                    if (q16 >= (64'd24 << 16)) begin
                        e.value = '0;
                    end else begin
                        e.value = 16'(half_exp(q16));
                        n_mid++;
                    end
                end
            end
            if (e.bad) n_bad++;
            if (e.value == 0) n_zero++;
            pending.push_back(e);
        endfunction

        function void check_result(logic [15:0] value, logic bad, logic last);
            t_kernel_result e;
            results++;
            if (pending.size() == 0) begin
                $error("unexpected result transaction value=%0d", value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $error("kernel_value expected %0d actual %0d", e.value, value);
                errors++;
            end
            if (bad !== e.bad) begin
                $error("invalid_cov expected %0d actual %0d", e.bad, bad);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_out expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [15:0] i_feature_x = '0;
    logic signed [15:0] i_feature_y = '0;
    logic               i_last_in = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [15:0]        o_kernel_value;
    logic               o_invalid_cov;
    logic               o_last_out;

    grbf_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;
    int  n_phases = 0;

    gaussian_rbf_kernel_2d u_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_point(i_feature_x, i_feature_y, i_last_in);
            if (o_valid && i_ready) sb.check_result(o_kernel_value, o_invalid_cov, o_last_out);
        end
    end

    function automatic int pick_gap();
        if (quiet) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // output stall pattern
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            i_ready <= 1;
            g = pick_gap();
            if (g > 0) begin
                @(negedge i_clk);
                i_ready <= 0;
                repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic set_config(logic [15:0] cx, logic [15:0] cy, logic [15:0] xx,
                              logic [15:0] xy, logic [15:0] yx, logic [15:0] yy,
                              logic cm);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_COV_XX, xx);
        write_reg(REG_COV_XY, xy);
        write_reg(REG_COV_YX, yx);
        write_reg(REG_COV_YY, yy);
        write_reg(REG_CONSTANT_MODE, {15'd0, cm});
    endtask

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
        int g;
        g = pick_gap();
        @(negedge i_clk);
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid     <= 1;
        i_feature_x <= x;
        i_feature_y <= y;
        i_last_in   <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near(logic [15:0] c, int s);
        return c + 16'($urandom_range(0, 2 * s) - s);
    endfunction

    task automatic random_phase(int n);
        int          kind, s;
        logic [15:0] cx, cy, v, w;
        kind = $urandom_range(0, 6);
        cx = 16'($urandom);
        cy = 16'($urandom);
        if ($urandom_range(0, 1)) begin
            cx = near(16'd0, 2000);
            cy = near(16'd0, 2000);
        end
        v = 16'($urandom_range(16, 2048));
        w = 16'($urandom_range(16, 2048));
        case (kind)
            0: set_config(cx, cy, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 1'b0);
            1: set_config(cx, cy, v, near(16'd0, 8), near(16'd0, 8), w, 1'b0);
            2: set_config(cx, cy, v, v, v, v, 1'b0);
            3: set_config(cx, cy, v, 16'd0, 16'd0, -w, 1'b0);
            4: set_config(cx, cy, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
            5: set_config(cx, cy, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 1'b1);
            default: set_config(cx, cy, v, near(16'd0, 64), near(16'd0, 64), v, 1'b0);
        endcase
        if ($urandom_range(0, 3) == 0) write_reg(3'd7, 16'($urandom));
        s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(50, 1500);
        for (int i = 0; i < n; i++) begin
            if (s == 0 || $urandom_range(0, 15) == 0) begin
                send_point(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                send_point(near(cx, s), near(cy, s), $urandom_range(0, 7) == 0);
            end
        end
        drain();
        n_phases++;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // default identity covariance: zero form, mid range, large form
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd256, 16'd0, 1'b1);
        send_point(-16'sd256, 16'd256, 1'b0);
        send_point(16'd1, -16'sd1, 1'b0);
        send_point(16'd600, 16'd300, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b1);
        drain();
        // singular covariance
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd100, 16'hff00, 1'b1);
        drain();
        // negative form
        set_config(16'h7fff, 16'h8000, -16'sd256, 16'd0, 16'd0, -16'sd256, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b1);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h7f00, 16'h8000, 1'b0);
        drain();
        // constant mode with a singular matrix
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_point(16'h1234, 16'h8765, 1'b1);
        send_point(16'd0, 16'd0, 1'b0);
        drain();
        write_reg(3'd7, 16'hffff);
        set_config(16'd256, 16'hff00, 16'd512, 16'd100, 16'd50, 16'd256, 1'b0);
        send_point(16'd256, 16'hff00, 1'b0);
        send_point(16'd512, 16'd0, 1'b1);
        drain();

        for (int p = 0; p < 12; p++) begin
            quiet = (p % 4 == 3);
            random_phase(70);
        end

        $display("points %0d results %0d over %0d random settings", sb.points, sb.results,
                 n_phases);
        $display("invalid %0d, zero %0d, in exp range %0d", sb.n_bad, sb.n_zero, sb.n_mid);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
